// ===== rtl/rphm_pkg.sv =====
// Shared types, register codes, reset values and the color test of the red pixel mask.
package rphm_pkg;

  localparam int RPHM_MAX_WIDTH  = 1024;
  localparam int RPHM_MAX_HEIGHT = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Reset values of the configuration registers.
  localparam int IMAGE_WIDTH_RST  = 640;
  localparam int IMAGE_HEIGHT_RST = 480;
  localparam logic [7:0] STRICT_SAT_RST    = 8'd60;
  localparam logic [7:0] STRICT_RED_RST    = 8'd120;
  localparam logic [7:0] STRICT_MARGIN_RST = 8'd60;
  localparam logic [7:0] LOOSE_SAT_RST     = 8'd40;
  localparam logic [7:0] LOOSE_RED_RST     = 8'd100;
  localparam logic [7:0] LOOSE_MARGIN_RST  = 8'd40;

  // Ratio tests are 5*R > k*(G+1): k = 8 gives 1.6, k = 7 gives 1.4.
  localparam int RATIO_SCALE  = 5;
  localparam int RATIO_STRICT = 8;
  localparam int RATIO_LOOSE  = 7;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT,
    CFG_STRICT_SAT,
    CFG_STRICT_RED,
    CFG_STRICT_MARGIN,
    CFG_LOOSE_SAT,
    CFG_LOOSE_RED,
    CFG_LOOSE_MARGIN
  } cfg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rphm_in_t;

  typedef struct packed {
    logic is_red;
    logic end_of_frame;
  } rphm_out_t;

  // One color test: saturation, red level, red margins and the red ratio.
  function automatic logic color_test(input logic [7:0] b, input logic [7:0] g,
                                      input logic [7:0] r, input logic [7:0] sat_min,
                                      input logic [7:0] red_min,
                                      input logic [7:0] margin_min,
                                      input logic [3:0] ratio);
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [11:0] r_scaled;
    logic [11:0] g_scaled;
    logic [11:0] b_scaled;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    r_scaled = 12'(RATIO_SCALE) * {4'b0, r};
    g_scaled = {8'b0, ratio} * ({4'b0, g} + 12'd1);
    b_scaled = {8'b0, ratio} * ({4'b0, b} + 12'd1);
    return ((mx - mn) > sat_min) && (r > red_min) &&
           ({1'b0, r} > ({1'b0, g} + {1'b0, margin_min})) &&
           ({1'b0, r} > ({1'b0, b} + {1'b0, margin_min})) &&
           (r_scaled > g_scaled) && (r_scaled > b_scaled);
  endfunction

endpackage

// ===== rtl/rphm_ram.sv =====
// Generic single write port RAM with one registered read port.
module rphm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/red_pixel_hysteresis_mask.sv =====
// Red pixel mask with hysteresis over a 3x3 window, one mask bit per raster pixel.
// Throughput is one word per cycle in both directions while the output is not stalled;
// the previous mask bit feeds back into the next decision.
// A word that produces a result passes the input word, window and output word registers in turn.
// Reset is asynchronous and active low: registers return to their reset values and all
// positions and counts clear; line memories are not cleared and need no clearing pass.
module red_pixel_hysteresis_mask
  import rphm_pkg::*;
#(
  parameter int MAX_WIDTH  = RPHM_MAX_WIDTH,
  parameter int MAX_HEIGHT = RPHM_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rphm_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rphm_out_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Widths: CW holds the row length plus two (ring size and fill count), AW addresses the
  // flag ring, XW a column, HW the frame height, YW a row.
  localparam int CW  = $clog2(MAX_WIDTH + 3);
  localparam int CW1 = CW + 1;
  localparam int AW  = $clog2(MAX_WIDTH + 2);
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = HW + 1;
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int RING_DEPTH = MAX_WIDTH + 2;
  localparam int W_RST = (IMAGE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RST;
  localparam int H_RST = (IMAGE_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : IMAGE_HEIGHT_RST;

  // Configuration. Frame sizes are stored already clamped to the legal range.
  logic [CW-1:0] w_q;
  logic [HW-1:0] h_q;
  logic [7:0]    s_sat_q, s_red_q, s_mar_q;
  logic [7:0]    l_sat_q, l_red_q, l_mar_q;
  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          restart;

  always_comb begin
    if (cfg_data_i == '0) begin
      w_eff = CW'(1);
      h_eff = HW'(1);
    end else begin
      w_eff = (int'(cfg_data_i) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(cfg_data_i);
      h_eff = (int'(cfg_data_i) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data_i);
    end
  end

  // Writing either frame size starts a new frame from an empty window.
  assign restart = cfg_we_i && ((cfg_idx_i == CFG_IMAGE_WIDTH) ||
                                (cfg_idx_i == CFG_IMAGE_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= CW'(W_RST);
      h_q     <= HW'(H_RST);
      s_sat_q <= STRICT_SAT_RST;
      s_red_q <= STRICT_RED_RST;
      s_mar_q <= STRICT_MARGIN_RST;
      l_sat_q <= LOOSE_SAT_RST;
      l_red_q <= LOOSE_RED_RST;
      l_mar_q <= LOOSE_MARGIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:   w_q     <= w_eff;
        CFG_IMAGE_HEIGHT:  h_q     <= h_eff;
        CFG_STRICT_SAT:    s_sat_q <= cfg_data_i[7:0];
        CFG_STRICT_RED:    s_red_q <= cfg_data_i[7:0];
        CFG_STRICT_MARGIN: s_mar_q <= cfg_data_i[7:0];
        CFG_LOOSE_SAT:     l_sat_q <= cfg_data_i[7:0];
        CFG_LOOSE_RED:     l_red_q <= cfg_data_i[7:0];
        CFG_LOOSE_MARGIN:  l_mar_q <= cfg_data_i[7:0];
      endcase
    end
  end

  // Pipeline flow. Three register levels: the input word, the window stage (which
  // also receives the memory read data) and the output word. A stage moves when the
  // stage after it is empty or moving, so bubbles collapse and the input is only held
  // back when every level is full and the output is stalled.
  logic v1_q, v2_q, e2_q, out_v_q;
  logic en1, en2, en3, mv1, mv2e;

  assign en3 = !out_v_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  rphm_in_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      in_q <= in_data_i;
    end
  end

  assign mv1 = v1_q && en2;

  // Stage 1: classify the pixel and do the window bookkeeping.
  // The ring holds the pending pixels in arrival order: rd_q is the oldest, which is the
  // pixel that comes out next, and wr_q the slot for the next arrival. hist_q keeps the
  // three newest flag pairs so that the row below and short fills never need the memory.
  logic [CW-1:0]      waiting_q;
  logic [AW-1:0]      rd_q, wr_q;
  logic [XW-1:0]      out_col_q;
  logic [YW-1:0]      out_row_q;
  logic [2:0][1:0]    hist_q;
  logic [2:0][1:0]    hist_n;
  logic               is_pix;
  logic [1:0]         flags_new;
  logic [CW-1:0]      k_cnt, n_ring, dw, rd_inc, wr_inc, col_inc;
  logic [AW-1:0]      rd_nx, wr_nx;
  logic [HW-1:0]      row_inc;
  logic               emit1, last_col, last_row, interior, eof;
  logic               use0, use1, valid1;
  logic [1:0]         fs0, pick1, pick_wm1, pick_w;
  logic               fs1, below;
  logic [XW-1:0]      fr_raddr;

  function automatic logic [1:0] hist_sel(input logic [2:0][1:0] h, input logic [1:0] idx);
    case (idx)
      2'd0:    return h[0];
      2'd1:    return h[1];
      2'd2:    return h[2];
      default: return 2'b00;
    endcase
  endfunction

  always_comb begin
    is_pix = (in_q.cmd == CMD_PIXEL);
    flags_new[0] = color_test(in_q.blue, in_q.green, in_q.red, s_sat_q, s_red_q, s_mar_q,
                              4'(RATIO_STRICT));
    flags_new[1] = color_test(in_q.blue, in_q.green, in_q.red, l_sat_q, l_red_q, l_mar_q,
                              4'(RATIO_LOOSE));
    hist_n = is_pix ? {hist_q[1], hist_q[0], flags_new} : hist_q;

    // k_cnt counts the pending pixels including the one that arrives now.
    n_ring = w_q + CW'(2);
    k_cnt  = is_pix ? (waiting_q + CW'(1)) : waiting_q;
    emit1  = is_pix ? (k_cnt == n_ring) : (waiting_q != '0);

    rd_inc = CW'(rd_q) + CW'(1);
    rd_nx  = (rd_inc == n_ring) ? '0 : AW'(rd_inc);
    wr_inc = CW'(wr_q) + CW'(1);
    wr_nx  = (wr_inc == n_ring) ? '0 : AW'(wr_inc);

    // The pixel that comes out and its right neighbor: from hist_q when they are among
    // the three newest, otherwise from the ring memory.
    use0   = (k_cnt > CW'(3));
    fs0    = hist_sel(hist_n, 2'(k_cnt - CW'(1)));
    valid1 = (k_cnt >= CW'(2));
    use1   = valid1 && (k_cnt > CW'(4));
    pick1  = hist_sel(hist_n, 2'(k_cnt - CW'(2)));
    fs1    = valid1 && !use1 && pick1[0];

    // Row below: the three pixels one row later are always among the three newest.
    // A neighbor that has not arrived yet counts as not red.
    dw       = k_cnt - w_q;
    pick_wm1 = hist_sel(hist_n, 2'(dw));
    pick_w   = hist_sel(hist_n, 2'(dw - CW'(1)));
    below    = ((k_cnt >= w_q) && pick_wm1[0]) ||
               ((k_cnt >= (w_q + CW'(1))) && pick_w[0]) ||
               ((k_cnt == n_ring) && hist_n[0][0]);

    // Position of the pixel that comes out.
    col_inc  = CW'(out_col_q) + CW'(1);
    row_inc  = HW'(out_row_q) + HW'(1);
    last_col = (col_inc == w_q);
    last_row = (row_inc >= h_q);
    eof      = last_row && last_col;
    interior = (out_row_q != '0) && ((RW'(out_row_q) + RW'(2)) <= RW'(h_q)) &&
               (out_col_q != '0) && ((CW'(out_col_q) + CW'(2)) <= w_q);

    // The mask line is read one column ahead; at the end of a row it wraps to column 0.
    fr_raddr = last_col ? '0 : XW'(col_inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= '0;
      rd_q      <= '0;
      wr_q      <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (restart) begin
      waiting_q <= '0;
      rd_q      <= '0;
      wr_q      <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (mv1) begin
      if (is_pix) begin
        wr_q <= wr_nx;
      end
      if (emit1) begin
        rd_q <= rd_nx;
        if (last_col) begin
          out_col_q <= '0;
          out_row_q <= last_row ? '0 : YW'(row_inc);
        end else begin
          out_col_q <= XW'(col_inc);
        end
      end
      if (is_pix) begin
        waiting_q <= emit1 ? waiting_q : k_cnt;
      end else if (emit1) begin
        waiting_q <= waiting_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv1 && is_pix) begin
      hist_q <= hist_n;
    end
  end

  // Flag ring, kept twice so that the oldest pixel and its right neighbor are read in
  // the same cycle.
  logic [1:0] ring0_rdata, ring1_rdata;
  logic       fr_rdata;
  logic       fin;
  logic [XW-1:0] col2_q;

  rphm_ram #(
    .WIDTH (2),
    .DEPTH (RING_DEPTH)
  ) u_ring0 (
    .clk_i   (clk_i),
    .we_i    (mv1 && is_pix),
    .waddr_i (wr_q),
    .wdata_i (flags_new),
    .re_i    (en2),
    .raddr_i (rd_q),
    .rdata_o (ring0_rdata)
  );

  rphm_ram #(
    .WIDTH (2),
    .DEPTH (RING_DEPTH)
  ) u_ring1 (
    .clk_i   (clk_i),
    .we_i    (mv1 && is_pix),
    .waddr_i (wr_q),
    .wdata_i (flags_new),
    .re_i    (en2),
    .raddr_i (rd_nx),
    .rdata_o (ring1_rdata)
  );

  // Mask line: the final bit of every column, overwritten as each pixel comes out, so
  // reading one column ahead yields the mask bit of the pixel above and to the right.
  rphm_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_mask_line (
    .clk_i   (clk_i),
    .we_i    (mv2e),
    .waddr_i (col2_q),
    .wdata_i (fin),
    .re_i    (en2),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  // Stage 2: the hysteresis decision.
  logic [1:0] fs0_q;
  logic       use0_q, fs1_q, use1_q, below_q, int_q, eof_q;
  logic       left_q, above_q, above_left_q;
  logic [1:0] f_s;
  logic       right_s, near;
  rphm_out_t  out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      e2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
      e2_q <= v1_q && emit1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      fs0_q   <= fs0;
      use0_q  <= use0;
      fs1_q   <= fs1;
      use1_q  <= use1;
      below_q <= below;
      int_q   <= interior;
      eof_q   <= eof;
      col2_q  <= out_col_q;
    end
  end

  assign mv2e = v2_q && e2_q && en3;

  always_comb begin
    f_s     = use0_q ? ring0_rdata : fs0_q;
    right_s = use1_q ? ring1_rdata[0] : fs1_q;
    // Above and to the left count with their final mask bits; right and below only
    // when strictly red.
    near    = fr_rdata || above_q || above_left_q || left_q || right_s || below_q;
    fin     = f_s[0] || (f_s[1] && int_q && near);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 1'b0;
    end else if (restart) begin
      left_q <= 1'b0;
    end else if (mv2e) begin
      left_q <= fin;
    end
  end

  // The last two up-right reads become the above and above-left bits of the next pixels.
  always_ff @(posedge clk_i) begin
    if (mv2e) begin
      above_q      <= fr_rdata;
      above_left_q <= above_q;
      out_q        <= '{is_red: fin, end_of_frame: eof_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en3) begin
      out_v_q <= v2_q && e2_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // The window never holds more than one row plus one pixel between words.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW1'(waiting_q) <= (CW1'(w_q) + CW1'(1)))
    else $error("pending pixel count exceeds one row plus one");

  // Ring pointers stay apart by exactly the pending count, modulo the ring size.
  a_ring_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CW1'(rd_q) + CW1'(waiting_q)) == CW1'(wr_q)) ||
    ((CW1'(rd_q) + CW1'(waiting_q)) == (CW1'(wr_q) + CW1'(n_ring))))
    else $error("ring read and write pointers disagree with the pending count");

  // The output position stays inside the frame.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(out_col_q) < w_q) && (HW'(out_row_q) < h_q))
    else $error("output position outside the frame");

  // The input is held back only when every stage is full and the output is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline could move");
`endif

endmodule

// ===== bench/tb_red_pixel_hysteresis_mask.sv =====
// Self-checking testbench of the red pixel hysteresis mask with a built-in predictor.
`timescale 1ns / 1ps

module tb_red_pixel_hysteresis_mask;
  import rphm_pkg::*;

  // This bound only catches a hang.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // This many cycles cover anything still in flight.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  rphm_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  rphm_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  red_pixel_hysteresis_mask u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Mask predictor. It keeps its own copy of the registers, the ring of flag
  // pairs of the pixels that wait for their window, the final bits of the row
  // above, and the position of the next pixel whose mask bit comes out.
  // ---------------------------------------------------------------------------
  int unsigned cfg_q [8];
  bit [1:0]    flag_ring [RPHM_MAX_WIDTH+2];   // bit 0 strict, bit 1 loose
  bit          row_above [RPHM_MAX_WIDTH];
  int unsigned out_r, out_c, wr_pos, n_waiting;
  bit          left_fin;

  // Expected mask words, oldest first.
  rphm_out_t   masks_due [$];

  // A size of zero counts as one, and a size above the maximum counts as the maximum.
  function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int unsigned frame_w();
    return clamp_size(cfg_q[int'(CFG_IMAGE_WIDTH)], RPHM_MAX_WIDTH);
  endfunction

  function automatic bit red_test(int b, int g, int r, int sat_min, int red_min, int margin_min,
                                  int ratio);
    int mx;
    int mn;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    return (mx - mn) > sat_min && r > red_min && (r - g) > margin_min &&
           (r - b) > margin_min && RATIO_SCALE * r > ratio * (g + 1) &&
           RATIO_SCALE * r > ratio * (b + 1);
  endfunction

  function automatic void restart_frame();
    wr_pos = 0;
    n_waiting = 0;
    out_r = 0;
    out_c = 0;
    left_fin = 1'b0;
  endfunction

  function automatic void reset_model();
    cfg_q[int'(CFG_IMAGE_WIDTH)]   = IMAGE_WIDTH_RST;
    cfg_q[int'(CFG_IMAGE_HEIGHT)]  = IMAGE_HEIGHT_RST;
    cfg_q[int'(CFG_STRICT_SAT)]    = STRICT_SAT_RST;
    cfg_q[int'(CFG_STRICT_RED)]    = STRICT_RED_RST;
    cfg_q[int'(CFG_STRICT_MARGIN)] = STRICT_MARGIN_RST;
    cfg_q[int'(CFG_LOOSE_SAT)]     = LOOSE_SAT_RST;
    cfg_q[int'(CFG_LOOSE_RED)]     = LOOSE_RED_RST;
    cfg_q[int'(CFG_LOOSE_MARGIN)]  = LOOSE_MARGIN_RST;
    foreach (flag_ring[i]) flag_ring[i] = '0;
    foreach (row_above[i]) row_above[i] = 1'b0;
    restart_frame();
  endfunction

  // Size registers keep 11 bits and restart the frame; thresholds keep the low byte.
  function automatic void apply_cfg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    if (idx inside {CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT}) begin
      cfg_q[int'(idx)] = v;
      restart_frame();
    end else begin
      cfg_q[int'(idx)] = v[7:0];
    end
  endfunction

  // Final mask bit of the pixel in ring slot 'slot'; 'avail' later slots hold arrived pixels.
  function automatic rphm_out_t emit_mask_bit(int unsigned slot, int unsigned avail);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned r;
    int unsigned c;
    int unsigned offs [4];
    bit [1:0]    f;
    bit          fin;
    rphm_out_t   res;
    w = frame_w();
    h = clamp_size(cfg_q[int'(CFG_IMAGE_HEIGHT)], RPHM_MAX_HEIGHT);
    n = w + 2;
    r = out_r;
    c = out_c % w;
    f = flag_ring[slot % n];
    fin = f[0];
    // An interior loose pixel turns red when any neighbor is red: the row above and the
    // left neighbor with their final bits, the rest only when they are strict.
    if (!fin && f[1] && r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w) begin
      fin = row_above[c-1] | row_above[c] | row_above[c+1] | left_fin;
      offs = '{1, w - 1, w, w + 1};
      foreach (offs[i])
        if (offs[i] <= avail && flag_ring[(slot + offs[i]) % n][0]) fin = 1'b1;
    end
    if (c == 0) row_above[w-1] = left_fin;
    else row_above[c-1] = left_fin;
    left_fin = fin;
    res.is_red = fin;
    res.end_of_frame = (r + 1 >= h && c + 1 == w);
    if (c + 1 >= w) begin
      out_c = 0;
      out_r = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      out_c = c + 1;
    end
    return res;
  endfunction

  // Steps the predictor by one accepted word; returns 1 when the word yields a mask word.
  function automatic bit predict_mask(rphm_in_t wd, output rphm_out_t res);
    int unsigned w;
    int unsigned n;
    int unsigned s;
    bit [1:0]    f;
    w = frame_w();
    n = w + 2;
    if (wd.cmd == CMD_DRAIN) begin
      if (n_waiting == 0) return 1'b0;
      s = (wr_pos % n + n - n_waiting) % n;
      res = emit_mask_bit(s, n_waiting - 1);
      n_waiting--;
      return 1'b1;
    end
    f[0] = red_test(wd.blue, wd.green, wd.red, cfg_q[int'(CFG_STRICT_SAT)],
                    cfg_q[int'(CFG_STRICT_RED)], cfg_q[int'(CFG_STRICT_MARGIN)], RATIO_STRICT);
    f[1] = red_test(wd.blue, wd.green, wd.red, cfg_q[int'(CFG_LOOSE_SAT)],
                    cfg_q[int'(CFG_LOOSE_RED)], cfg_q[int'(CFG_LOOSE_MARGIN)], RATIO_LOOSE);
    flag_ring[wr_pos % n] = f;
    wr_pos = (wr_pos % n + 1) % n;
    if (n_waiting >= w + 1) begin
      res = emit_mask_bit(wr_pos, w + 1);
      return 1'b1;
    end
    n_waiting++;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Output checker. Every accepted mask word is compared with the oldest one
  // that the predictor is waiting for.
  // ---------------------------------------------------------------------------
  int        mismatches = 0;
  rphm_out_t due_word;

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (masks_due.size() == 0) begin
        log_mismatch($sformatf("mask word with none expected: is_red %0b end_of_frame %0b",
                               out_data.is_red, out_data.end_of_frame));
      end else begin
        due_word = masks_due.pop_front();
        if (out_data.is_red !== due_word.is_red)
          log_mismatch($sformatf("is_red: expected %0b, got %0b", due_word.is_red,
                                 out_data.is_red));
        if (out_data.end_of_frame !== due_word.end_of_frame)
          log_mismatch($sformatf("end_of_frame: expected %0b, got %0b",
                                 due_word.end_of_frame, out_data.end_of_frame));
      end
    end
  end

  // The cycle counter ends a run that hangs.
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_red_pixel_hysteresis_mask: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It stalls in random bursts, holds off for a long stretch when asked to
  // (counted here), and outside such a hold never stalls once rx_calm is set.
  // ---------------------------------------------------------------------------
  bit rx_calm = 1'b0;
  bit tx_calm = 1'b0;
  bit rx_hold_req = 1'b0;
  int rx_hold_left = 0;
  int rx_burst_left = 0;

  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else if (rx_calm) begin
      out_stall <= 1'b0;
    end else if (rx_burst_left > 0) begin
      rx_burst_left--;
    end else begin
      rx_burst_left = $urandom_range(0, 9);
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  bit idle_now = 1'b1;

  // Offers one word, waits for the handshake, and records what it should produce.
  // A row with a typed result queues that value in place of the prediction.
  task automatic push_word(rphm_in_t wd, bit typed, rphm_out_t want);
    rphm_out_t res;
    bit        got;
    if (!tx_calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= wd;
    idle_now = 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = predict_mask(wd, res);
    if (typed) masks_due.push_back(want);
    else if (got) masks_due.push_back(res);
  endtask

  // Stops offering words and waits until every expected mask word has come out, then lets
  // pixels that produce no result leave the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (masks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    idle_now = 1'b1;
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    apply_cfg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Pixels lean toward strongly red, weakly red and ratio-boundary colors so that the
  // hysteresis has something to work on; the rest are uniform over all channel values.
  function automatic rphm_in_t rand_pixel();
    rphm_in_t px;
    int       r;
    int       g;
    int       b;
    case ($urandom_range(0, 4))
      0: begin
        r = $urandom_range(150, 255);
        g = $urandom_range(0, 70);
        b = $urandom_range(0, 70);
      end
      1: begin
        r = $urandom_range(90, 150);
        g = $urandom_range(0, 60);
        b = $urandom_range(0, 60);
      end
      2: begin
        r = $urandom_range(160, 255);
        g = (RATIO_SCALE * r) / RATIO_STRICT - 2 + $urandom_range(0, 2);
        b = $urandom_range(0, g);
      end
      default: begin
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
    endcase
    px.cmd = CMD_PIXEL;
    px.red = 8'(r);
    px.green = 8'(g);
    px.blue = 8'(b);
    return px;
  endfunction

  // Mostly small frames; now and then zero, the maximum, or a value beyond it.
  function automatic logic [CFG_DATA_W-1:0] rand_size(bit rows);
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      2: return 11'(RPHM_MAX_WIDTH);
      3, 4, 5: return rows ? 11'($urandom_range(7, 12)) : 11'($urandom_range(9, 48));
      default: return rows ? 11'($urandom_range(1, 6)) : 11'($urandom_range(1, 8));
    endcase
  endfunction

  // Threshold bytes with junk in the unused upper bits of the write data.
  function automatic logic [CFG_DATA_W-1:0] rand_thr();
    logic [7:0] v;
    case ($urandom_range(0, 5))
      0: v = 8'd0;
      1: v = 8'd255;
      2: v = 8'($urandom_range(0, 255));
      default: v = 8'($urandom_range(20, 130));
    endcase
    return {3'($urandom_range(0, 7)), v};
  endfunction

  // One random phase: a new setting while idle, a run of raster pixels with an occasional
  // stray drain, and usually a flush of the frame tail.
  task automatic run_phase(int n_items);
    rphm_in_t wd;
    int       k;
    if (!idle_now) settle();
    if ($urandom_range(0, 1) == 0) begin
      cfg_write(CFG_IMAGE_WIDTH, rand_size(1'b0));
      cfg_write(CFG_IMAGE_HEIGHT, rand_size(1'b1));
    end
    for (int i = int'(CFG_STRICT_SAT); i <= int'(CFG_LOOSE_MARGIN); i++)
      if ($urandom_range(0, 2) == 0) cfg_write(cfg_idx_e'(i), rand_thr());
    for (k = 0; k < n_items; k++) begin
      wd = rand_pixel();
      if ($urandom_range(0, 24) == 0) wd.cmd = CMD_DRAIN;
      push_word(wd, 1'b0, '0);
    end
    if ($urandom_range(0, 2) != 0) begin
      k = n_waiting + $urandom_range(0, 2);
      if (k > 64) k = 64;
      repeat (k) begin
        wd = rand_pixel();
        wd.cmd = CMD_DRAIN;
        push_word(wd, 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Expected results are typed in only for one-pixel frames,
  // where each mask bit is simply the strict flag and end_of_frame is always set.
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] value;
    rphm_in_t              word;
    bit                    typed;
    rphm_out_t             want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic plan_row_t cfg_row(cfg_idx_e idx, int unsigned v);
    plan_row_t row;
    row = '{kind: ROW_CFG, idx: idx, value: 11'(v), word: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t word_row(cmd_e cmd, int b, int g, int r);
    plan_row_t row;
    row = '{kind: ROW_WORD, idx: CFG_IMAGE_WIDTH, value: '0, word: '0, typed: 1'b0,
            want: '0};
    row.word.cmd = cmd;
    row.word.blue = 8'(b);
    row.word.green = 8'(g);
    row.word.red = 8'(r);
    return row;
  endfunction

  function automatic plan_row_t typed_row(cmd_e cmd, int b, int g, int r, bit red, bit eof);
    plan_row_t row;
    row = word_row(cmd, b, g, r);
    row.typed = 1'b1;
    row.want.is_red = red;
    row.want.end_of_frame = eof;
    return row;
  endfunction

  initial begin
    reset_model();

    // Drain right after reset, with nothing waiting: no result.
    plan.push_back(word_row(CMD_DRAIN, 8'hA5, 8'h5A, 8'hFF));
    // A width of zero counts as one, so every pixel is a whole frame.
    plan.push_back(cfg_row(CFG_IMAGE_WIDTH, 0));
    plan.push_back(cfg_row(CFG_IMAGE_HEIGHT, 1));
    plan.push_back(word_row(CMD_PIXEL, 0, 0, 255));
    plan.push_back(word_row(CMD_PIXEL, 0, 0, 0));
    plan.push_back(typed_row(CMD_PIXEL, 255, 255, 255, 1'b1, 1'b1));
    plan.push_back(typed_row(CMD_DRAIN, 0, 0, 0, 1'b0, 1'b1));
    plan.push_back(typed_row(CMD_DRAIN, 255, 255, 255, 1'b0, 1'b1));
    plan.push_back(word_row(CMD_DRAIN, 255, 255, 255));
    // A red minimum of 255 rules every pixel out; the ratio test sits on its boundary.
    plan.push_back(cfg_row(CFG_STRICT_SAT, 0));
    plan.push_back(cfg_row(CFG_STRICT_MARGIN, 0));
    plan.push_back(cfg_row(CFG_STRICT_RED, 255));
    plan.push_back(word_row(CMD_PIXEL, 0, 0, 255));
    plan.push_back(word_row(CMD_PIXEL, 0, 158, 255));
    plan.push_back(typed_row(CMD_PIXEL, 0, 159, 255, 1'b0, 1'b1));
    // Pixels already waiting keep the flags of the old threshold.
    plan.push_back(cfg_row(CFG_STRICT_RED, 0));
    plan.push_back(typed_row(CMD_PIXEL, 0, 0, 2, 1'b0, 1'b1));
    plan.push_back(word_row(CMD_PIXEL, 0, 0, 1));
    // A 3x3 frame whose center is loose and whose lower right corner is strict. The size
    // write also drops the two pixels still waiting from above.
    plan.push_back(cfg_row(CFG_IMAGE_WIDTH, 3));
    plan.push_back(cfg_row(CFG_IMAGE_HEIGHT, 3));
    plan.push_back(cfg_row(CFG_STRICT_SAT, 60));
    plan.push_back(cfg_row(CFG_STRICT_RED, 120));
    plan.push_back(cfg_row(CFG_STRICT_MARGIN, 60));
    plan.push_back(cfg_row(CFG_LOOSE_SAT, 40));
    plan.push_back(cfg_row(CFG_LOOSE_RED, 100));
    plan.push_back(cfg_row(CFG_LOOSE_MARGIN, 40));
    repeat (4) plan.push_back(word_row(CMD_PIXEL, 0, 0, 0));
    plan.push_back(word_row(CMD_PIXEL, 0, 0, 110));
    repeat (3) plan.push_back(word_row(CMD_PIXEL, 0, 0, 0));
    plan.push_back(word_row(CMD_PIXEL, 0, 0, 200));
    plan.push_back(word_row(CMD_DRAIN, 0, 0, 0));
    plan.push_back(word_row(CMD_DRAIN, 0, 0, 0));
    // Sizes beyond the maximum; the drains empty a frame in mid row.
    plan.push_back(cfg_row(CFG_IMAGE_WIDTH, 2047));
    plan.push_back(cfg_row(CFG_IMAGE_HEIGHT, 2047));
    plan.push_back(word_row(CMD_PIXEL, 0, 0, 255));
    plan.push_back(word_row(CMD_PIXEL, 17, 200, 99));
    plan.push_back(word_row(CMD_DRAIN, 0, 0, 0));
    plan.push_back(word_row(CMD_DRAIN, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (!idle_now) settle();
        cfg_write(plan[i].idx, plan[i].value);
      end else begin
        push_word(plan[i].word, plan[i].typed, plan[i].want);
      end
    end

    repeat (14) run_phase(40);

    // Back pressure: the receiver holds off while the sender keeps offering pixels, so the
    // block fills and stalls its input. The sender then pauses until every result is out.
    settle();
    cfg_write(CFG_IMAGE_WIDTH, 4);
    cfg_write(CFG_IMAGE_HEIGHT, 4);
    tx_calm = 1'b1;
    rx_hold_req = 1'b1;
    repeat (80) push_word(rand_pixel(), 1'b0, '0);
    tx_calm = 1'b0;
    settle();

    // The last part runs at full rate on both sides.
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (2) run_phase(40);

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && masks_due.size() == 0) begin
      $display("tb_red_pixel_hysteresis_mask: done, clean");
    end else begin
      $display("tb_red_pixel_hysteresis_mask: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rphm_pkg.sv
rtl/rphm_ram.sv
rtl/red_pixel_hysteresis_mask.sv
bench/tb_red_pixel_hysteresis_mask.sv
